### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/pcmn_pkg.sv
// ----------------------------------------------------------------------------
// pcmn_pkg
// shared types, constants and the drum note table for the pad to midi block
// ----------------------------------------------------------------------------
package pcmn_pkg;

    // number of pads in use; scan is always eight bits wide
    localparam int PAD_COUNT = 8;
    localparam int SCAN_W    = 8;
    localparam int IDX_W     = 3;

    // pads at or above PAD_COUNT are masked off
    localparam logic [SCAN_W-1:0] PAD_MASK =
        (PAD_COUNT >= SCAN_W) ? {SCAN_W{1'b1}} : SCAN_W'((1 << PAD_COUNT) - 1);

    localparam logic [7:0] NOTE_ON_STATUS = 8'h90;

    // register reset values
    localparam logic [3:0] CHANNEL_RESET  = 4'd9;
    localparam logic [6:0] VELOCITY_RESET = 7'd120;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIDI_CHANNEL   = 2'd0,
        CFG_PRESS_VELOCITY = 2'd1
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS,
        ST_NOTE,
        ST_VEL
    } state_t;

    // which byte of a note-on message is formed
    typedef enum logic [1:0] {
        BYTE_STATUS,
        BYTE_NOTE,
        BYTE_VEL
    } byte_kind_t;

    // request from the sequencer to the byte unit
    typedef struct packed {
        byte_kind_t       kind;
        logic [IDX_W-1:0] idx;
        logic             touched;
    } byte_req_t;

    // fixed drum note per pad
    function automatic logic [7:0] drum_note(input logic [IDX_W-1:0] idx);
        logic [7:0] note;
        unique case (idx)
            3'd0:    note = 8'h34;
            3'd1:    note = 8'h2E;
            3'd2:    note = 8'h2D;
            3'd3:    note = 8'h29;
            3'd4:    note = 8'h2A;
            3'd5:    note = 8'h27;
            3'd6:    note = 8'h26;
            default: note = 8'h23;
        endcase
        return note;
    endfunction

endpackage

### rtl/pad_change_to_midi_note_on_unit.sv
// ----------------------------------------------------------------------------
// pad_change_to_midi_note_on_unit
// drum-pad scan to midi note-on byte stream
// ----------------------------------------------------------------------------
// the first byte is registered once the sequencer has walked from pad zero
//   to the first changed pad; pads are visited one per cycle and bytes are
//   formed one per cycle while the output register is free; a new scan is
//   taken only when the sequencer is idle
// an unchanged scan sends nothing
// reset: async active low; previous scan cleared, channel 9, velocity 120
`include "assert_macros.svh"

module pad_change_to_midi_note_on_unit (
    input  logic       clk,
    input  logic       rst_n,
    // scan input; tdata: pad_bits[7:0]
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    // byte output; tdata: midi_byte[7:0], tlast: last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import pcmn_pkg::*;

    logic [SCAN_W-1:0] prev_reg, prev_next;
    logic [SCAN_W-1:0] now_reg, now_next;
    logic [3:0]        chan_reg;
    logic [6:0]        vel_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    logic              s_xfer;
    logic              out_free;
    logic              idle;
    logic              emit;
    logic              emit_last;
    byte_req_t         req;
    state_t            state;
    logic [SCAN_W-1:0] pending;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        byte_val;
    logic [SCAN_W-1:0] masked;

    assign s_tready  = idle;
    assign s_xfer    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign masked    = s_tdata & PAD_MASK;

    // scan history
    always_comb
    begin
        prev_next = prev_reg;
        now_next  = now_reg;
        if (s_xfer)
        begin
            prev_next = masked;
            now_next  = masked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else
            prev_reg <= prev_next;
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= CHANNEL_RESET;
            vel_reg  <= VELOCITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MIDI_CHANNEL)
                chan_reg <= cfg_data[3:0];
            else if (cfg_index == CFG_PRESS_VELOCITY)
                vel_reg <= cfg_data[6:0];
        end
    end

    // pad walker and byte sequencer
    pcmn_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_xfer),
        .changed   (masked ^ prev_reg),
        .now_pads  (now_reg),
        .out_free  (out_free),
        .idle      (idle),
        .emit      (emit),
        .emit_last (emit_last),
        .req       (req),
        .state     (state),
        .pending   (pending),
        .idx       (idx)
    );

    // shared byte former
    pcmn_byte_unit u_byte (
        .req            (req),
        .midi_channel   (chan_reg),
        .press_velocity (vel_reg),
        .midi_byte      (byte_val)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= byte_val;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `ASSERT_CLK(a_idle_no_pending, clk, rst_n, s_tready |-> (pending == '0),
        "ready with pads still pending")
    `ASSERT_CLK(a_msg_on_changed_pad, clk, rst_n,
        (state == ST_STATUS || state == ST_NOTE || state == ST_VEL) |-> pending[idx],
        "message formed for a pad that did not change")
    `ASSERT_CLK(a_walk_from_pad0, clk, rst_n, s_xfer |=> (idx == '0),
        "pad walk does not start at pad zero")
    `ASSERT_NEVER(a_emit_over_full, clk, rst_n, emit && out_valid_reg && !m_tready,
        "byte formed while output register is held")

endmodule

### rtl/pcmn_byte_unit.sv
// ----------------------------------------------------------------------------
// pcmn_byte_unit
// shared byte former: status, note or velocity byte for the current pad
// ----------------------------------------------------------------------------
module pcmn_byte_unit (
    input  pcmn_pkg::byte_req_t req,
    input  logic [3:0]          midi_channel,
    input  logic [6:0]          press_velocity,
    output logic [7:0]          midi_byte
);
    import pcmn_pkg::*;

    // one selected byte per cycle
    always_comb
    begin
        unique case (req.kind)
            BYTE_STATUS: midi_byte = NOTE_ON_STATUS + {4'd0, midi_channel};
            BYTE_NOTE:   midi_byte = drum_note(req.idx);
            BYTE_VEL:    midi_byte = req.touched ? {1'b0, press_velocity} : 8'd0;
            default:     midi_byte = 8'd0;
        endcase
    end

endmodule

### rtl/pcmn_sequencer.sv
// ----------------------------------------------------------------------------
// pcmn_sequencer
// walks pads one per cycle, stopping at each changed pad for its three bytes
// ----------------------------------------------------------------------------
module pcmn_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcmn_pkg::SCAN_W-1:0]   changed,
    input  logic [pcmn_pkg::SCAN_W-1:0]   now_pads,
    input  logic                          out_free,
    output logic                          idle,
    output logic                          emit,
    output logic                          emit_last,
    output pcmn_pkg::byte_req_t           req,
    output pcmn_pkg::state_t              state,
    output logic [pcmn_pkg::SCAN_W-1:0]   pending,
    output logic [pcmn_pkg::IDX_W-1:0]    idx
);
    import pcmn_pkg::*;

    state_t             state_reg, state_next;
    logic [SCAN_W-1:0]  chg_reg, chg_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SCAN_W-1:0]  cur_bit;
    logic [SCAN_W-1:0]  rest;

    assign cur_bit = SCAN_W'(1) << idx_reg;
    assign rest    = chg_reg & ~cur_bit;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chg_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chg_reg   <= chg_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        chg_next   = chg_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    chg_next   = changed;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                priority if (chg_reg == '0)
                    state_next = ST_IDLE;
                else if (chg_reg[idx_reg])
                    state_next = ST_STATUS;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_STATUS:
            begin
                if (out_free)
                    state_next = ST_NOTE;
            end
            ST_NOTE:
            begin
                if (out_free)
                    state_next = ST_VEL;
            end
            ST_VEL:
            begin
                if (out_free)
                begin
                    chg_next   = rest;
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = (rest == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        idle        = 1'b0;
        emit        = 1'b0;
        emit_last   = 1'b0;
        req.kind    = BYTE_STATUS;
        req.idx     = idx_reg;
        req.touched = now_pads[idx_reg];
        unique case (state_reg)
            ST_IDLE:   idle = 1'b1;
            ST_SCAN:   emit = 1'b0;
            ST_STATUS: emit = out_free;
            ST_NOTE:
            begin
                emit     = out_free;
                req.kind = BYTE_NOTE;
            end
            ST_VEL:
            begin
                emit      = out_free;
                emit_last = (rest == '0);
                req.kind  = BYTE_VEL;
            end
            default:   idle = 1'b0;
        endcase
    end

    assign state   = state_reg;
    assign pending = chg_reg;
    assign idx     = idx_reg;

endmodule

### tb/sv/pcmn_note_on_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcmn_note_on_checker
// watches the scan, byte and configuration channels of the pad to midi block,
// works out the note-on bytes each accepted scan must produce and compares
// every byte leaving the block with the oldest one still awaited
// ----------------------------------------------------------------------------
module pcmn_note_on_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending_bytes
);
    import pcmn_pkg::*;

    // pads at or above the pad count never take part
    localparam logic [7:0] ACTIVE_PADS =
        (PAD_COUNT >= 8) ? 8'hFF : 8'((1 << PAD_COUNT) - 1);

    // drum note of each pad, pad 0 first
    localparam logic [7:0] PAD_NOTE [8] = '{
        8'h34, 8'h2E, 8'h2D, 8'h29, 8'h2A, 8'h27, 8'h26, 8'h23
    };

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } midi_byte_t;

    midi_byte_t expected_bytes [$];
    logic [3:0] channel;
    logic [6:0] velocity;
    logic [7:0] prev_pads;

    initial fail_count = 0;

    // one line per mismatch, counted
    task report_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        $display("%0t ns: %s differs, expected %02h, got %02h", $time, what, want, got);
        fail_count++;
    endtask

    task push_expected(input logic [7:0] value, input logic is_last);
        midi_byte_t entry;
        entry.midi_byte = value;
        entry.last_byte = is_last;
        expected_bytes.push_back(entry);
    endtask

    // note-on bytes for every pad that changed since the previous scan
    task predict_note_ons(input logic [7:0] pad_bits);
        logic [7:0] now_pads;
        logic [7:0] changed;
        int         last_pad;
        now_pads = pad_bits & ACTIVE_PADS;
        changed  = now_pads ^ prev_pads;
        last_pad = -1;
        for (int i = 0; i < 8; i++)
            if (changed[i])
                last_pad = i;
        for (int i = 0; i < 8; i++)
        begin
            if (changed[i])
            begin
                push_expected(NOTE_ON_STATUS + {4'd0, channel}, 1'b0);
                push_expected(PAD_NOTE[i], 1'b0);
                push_expected(now_pads[i] ? {1'b0, velocity} : 8'd0, i == last_pad);
            end
        end
        prev_pads = now_pads;
    endtask

    // monitor all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        midi_byte_t want;
        if (!rst_n)
        begin
            channel   = CHANNEL_RESET;
            velocity  = VELOCITY_RESET;
            prev_pads = '0;
            expected_bytes.delete();
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIDI_CHANNEL)
                    channel = cfg_data[3:0];
                else if (cfg_index == CFG_PRESS_VELOCITY)
                    velocity = cfg_data[6:0];
            end
            // byte transfer
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected midi_byte", 8'h00, m_tdata);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.midi_byte)
                        report_mismatch("midi_byte", want.midi_byte, m_tdata);
                    if (m_tlast !== want.last_byte)
                        report_mismatch("last_byte", {7'd0, want.last_byte}, {7'd0, m_tlast});
                end
            end
            // scan transfer
            if (s_tvalid && s_tready)
                predict_note_ons(s_tdata);
        end
        pending_bytes = expected_bytes.size();
    end

endmodule

### tb/sv/tb_pad_change_to_midi_note_on_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pad_change_to_midi_note_on_unit
// drives pad scans and register writes into the pad to midi block under
// several idle and stall patterns, including a long output hold-off that
// backs the block up; the checker beside the block judges every byte
// ----------------------------------------------------------------------------
module tb_pad_change_to_midi_note_on_unit;
    import pcmn_pkg::*;

    // register indexes with no register behind them
    localparam logic [1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [1:0] CFG_UNUSED_3 = 2'd3;

    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_ITEMS     = 48;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int         fail_count;
    int         pending_bytes;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_active = 1'b0;
    logic [7:0] last_scan = 8'h00;
    event       hold_off_ev;

    pad_change_to_midi_note_on_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pcmn_note_on_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_bytes (pending_bytes)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // long output hold-off, counted here
    always
    begin
        @(hold_off_ev);
        hold_active = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_active = 1'b0;
    end

    // output side ready, random stalls
    always @(negedge clk)
        m_tready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);

    // one scan transfer, with random idle cycles ahead of it
    task send_scan(input logic [7:0] scan);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= scan;
        do @(posedge clk); while (!s_tready);
        last_scan = scan;
    endtask

    // wait until every awaited byte is out and the block has settled
    task wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write transfer
    task write_reg(input logic [1:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // next random scan: a random byte, a one-pad change, a repeat, the inverse, or all pads on or off
    function automatic logic [7:0] next_scan(input logic [7:0] prev);
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return 8'($urandom);
        else if (pick < 70)
            return prev ^ (8'h01 << $urandom_range(7));
        else if (pick < 80)
            return prev;
        else if (pick < 90)
            return ~prev;
        else
            return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    int send_pct_of [RANDOM_PHASES] = '{0, 45, 0, 29};
    int recv_pct_of [RANDOM_PHASES] = '{0, 0, 45, 29};

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIDI_CHANNEL;
        cfg_data  = 8'h00;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed scans at reset settings: unchanged, single pads, all pads
        send_scan(8'h00);
        send_scan(8'h01);
        send_scan(8'h00);
        send_scan(8'hFF);
        send_scan(8'hFF);
        send_scan(8'h00);
        send_scan(8'h80);
        send_scan(8'h81);
        send_scan(8'h55);
        send_scan(8'hAA);
        send_scan(8'h0F);
        wait_quiet();

        // lowest settings
        write_reg(CFG_MIDI_CHANNEL, 8'h00);
        write_reg(CFG_PRESS_VELOCITY, 8'h00);
        send_scan(8'hF0);
        send_scan(8'h00);
        wait_quiet();

        // highest settings
        write_reg(CFG_MIDI_CHANNEL, 8'h0F);
        write_reg(CFG_PRESS_VELOCITY, 8'h7F);
        send_scan(8'h3C);
        send_scan(8'hC3);
        wait_quiet();

        // values wider than the registers keep their low bits
        write_reg(CFG_MIDI_CHANNEL, 8'hF5);
        write_reg(CFG_PRESS_VELOCITY, 8'hFF);
        send_scan(8'h18);
        wait_quiet();
        write_reg(CFG_PRESS_VELOCITY, 8'h80);
        send_scan(8'hE7);
        wait_quiet();

        // writes to indexes without a register change nothing
        write_reg(CFG_UNUSED_2, 8'($urandom));
        write_reg(CFG_UNUSED_3, 8'($urandom));
        write_reg(CFG_PRESS_VELOCITY, 8'h40);
        send_scan(8'h00);
        send_scan(8'hFF);
        wait_quiet();

        // random phases, each under its own idle pattern and settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_reg(CFG_MIDI_CHANNEL, 8'($urandom));
            write_reg(CFG_PRESS_VELOCITY, 8'($urandom));
            if ($urandom_range(1))
                write_reg($urandom_range(1) ? CFG_UNUSED_2 : CFG_UNUSED_3, 8'($urandom));
            send_idle_pct = send_pct_of[ph];
            recv_idle_pct = recv_pct_of[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_scan(next_scan(last_scan));
            wait_quiet();
        end

        // output held off while full scans keep coming, so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MIDI_CHANNEL, {4'd0, CHANNEL_RESET});
        write_reg(CFG_PRESS_VELOCITY, {1'b0, VELOCITY_RESET});
        @(negedge clk);
        -> hold_off_ev;
        for (int n = 0; n < 10; n++)
            send_scan(last_scan ^ 8'hFF);

        // drain and verdict
        wait_quiet();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
